// ===== rtl/core/qn_pkg.sv =====
// Shared constants for the quaternion normaliser.
package qn_pkg;
	localparam int DEF_COMPONENT_WIDTH = 16;
	localparam int QB = 15;
	localparam int OUT_W = 16;
	localparam int RHS_SHIFT = 30;
	localparam int LANES = 4;
	localparam logic [QB-1:0] UNIT_ONE = 15'd16384;
	localparam logic [OUT_W-1:0] UNIT_ONE_OUT = 16'd16384;
endpackage

// ===== rtl/core/qn_step.sv =====
// One bit of the quotient search for one lane.
module qn_step #(
	parameter int XW = 66,
	parameter int BIT = 14
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [XW-1:0]     s,
	input  logic signed [XW-1:0]     rhs,
	input  logic signed [XW-1:0]     p,
	input  logic signed [XW-1:0]     t,
	input  logic [qn_pkg::QB-1:0]    q,
	input  logic                     neg,
	output logic signed [XW-1:0]     s_q,
	output logic signed [XW-1:0]     rhs_q,
	output logic signed [XW-1:0]     p_q,
	output logic signed [XW-1:0]     t_q,
	output logic [qn_pkg::QB-1:0]    q_q,
	output logic                     neg_q
);
	localparam logic [qn_pkg::QB-1:0] BIT_MASK = qn_pkg::QB'(1) << BIT;

	logic signed [XW-1:0] p_new;
	logic take;

	assign p_new = p + (t <<< (BIT + 2)) + (s <<< (2 * BIT + 2));
	assign take = !q[qn_pkg::QB-1] && (p_new <= rhs);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_q <= s;
			rhs_q <= rhs;
			neg_q <= neg;
			if (take) begin
				p_q <= p_new;
				t_q <= t + (s <<< (BIT + 1));
				q_q <= q | BIT_MASK;
			end else begin
				p_q <= p;
				t_q <= t;
				q_q <= q;
			end
		end
	end
endmodule

// ===== rtl/core/qn_lane.sv =====
// One lane: chain of search steps and signed Q1.14 result for one component.
module qn_lane #(
	parameter int XW = 66
) (
	input  logic                     clk,
	input  logic                     adv,
	input  logic signed [XW-1:0]     s,
	input  logic signed [XW-1:0]     rhs,
	input  logic                     neg,
	output logic [qn_pkg::OUT_W-1:0] unit
);
	logic signed [XW-1:0] s_c   [0:qn_pkg::QB];
	logic signed [XW-1:0] rhs_c [0:qn_pkg::QB];
	logic signed [XW-1:0] p_c   [0:qn_pkg::QB];
	logic signed [XW-1:0] t_c   [0:qn_pkg::QB];
	logic [qn_pkg::QB-1:0] q_c  [0:qn_pkg::QB];
	logic neg_c [0:qn_pkg::QB];
	logic [qn_pkg::QB-1:0] q_sat;
	logic [qn_pkg::OUT_W-1:0] q_ext;

	assign s_c[0] = s;
	assign rhs_c[0] = rhs;
	assign p_c[0] = s;
	assign t_c[0] = -s;
	assign q_c[0] = '0;
	assign neg_c[0] = neg;

	for (genvar i = 0; i < qn_pkg::QB; i++) begin : g_step
		qn_step #(.XW(XW), .BIT(qn_pkg::QB - 1 - i)) u_step (
			.clk(clk), .adv(adv),
			.s(s_c[i]), .rhs(rhs_c[i]), .p(p_c[i]), .t(t_c[i]),
			.q(q_c[i]), .neg(neg_c[i]),
			.s_q(s_c[i+1]), .rhs_q(rhs_c[i+1]), .p_q(p_c[i+1]), .t_q(t_c[i+1]),
			.q_q(q_c[i+1]), .neg_q(neg_c[i+1])
		);
	end

	assign q_sat = (q_c[qn_pkg::QB] > qn_pkg::UNIT_ONE) ? qn_pkg::UNIT_ONE
		: q_c[qn_pkg::QB];
	assign q_ext = {1'b0, q_sat};
	assign unit = neg_c[qn_pkg::QB] ? (~q_ext + 16'd1) : q_ext;
endmodule

// ===== rtl/core/quaternion_normalise_core.sv =====
// Quaternion normaliser top level: front end, four lanes, merge and output register.
// Usage:
//  Request channel: comp_w/x/y/z (signed Q3.12) with req_valid/req_stall; a request
//  is taken on a rising edge with req_valid high and req_stall low.
//  Result channel: unit_w/x/y/z (signed Q1.14) and zero_magnitude with
//  res_valid/res_stall, taken when res_valid is high and res_stall low.
//  Each component is c / sqrt(w^2+x^2+y^2+z^2), rounded to nearest with ties
//  away from zero; an all-zero request returns (1,0,0,0) with zero_magnitude set.
//  Pipeline: square, sum, 15 search stages of one quotient bit each,
//  output register.
//  Throughput: one request per cycle while the pipeline is not stalled; four
//  lanes run the bit search in parallel, one pipeline stage per quotient bit.
//  Stall: when the output register is full and res_stall is high, the whole
//  pipeline holds and req_stall rises in the same cycle.
//  Reset: arst_n clears all valid bits; no other setup is needed.
module quaternion_normalise_core #(
	parameter int COMPONENT_WIDTH = qn_pkg::DEF_COMPONENT_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [COMPONENT_WIDTH-1:0]  comp_w,
	input  logic [COMPONENT_WIDTH-1:0]  comp_x,
	input  logic [COMPONENT_WIDTH-1:0]  comp_y,
	input  logic [COMPONENT_WIDTH-1:0]  comp_z,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [qn_pkg::OUT_W-1:0]    unit_w,
	output logic [qn_pkg::OUT_W-1:0]    unit_x,
	output logic [qn_pkg::OUT_W-1:0]    unit_y,
	output logic [qn_pkg::OUT_W-1:0]    unit_z,
	output logic                        zero_magnitude
);
	localparam int W = COMPONENT_WIDTH;
	localparam int SW = 2 * W + 1;
	localparam int XW = 2 * W + 34;
	localparam int L = qn_pkg::LANES;

	logic adv;
	logic [W-1:0] comp [0:L-1];
	logic [W-1:0] mag [0:L-1];
	logic [2*W-1:0] sq_s1 [0:L-1];
	logic neg_s1 [0:L-1];
	logic v_s1;
	logic [SW-1:0] sum;
	logic signed [XW-1:0] s_s2;
	logic signed [XW-1:0] rhs_s2 [0:L-1];
	logic neg_s2 [0:L-1];
	logic v_s2;
	logic [qn_pkg::QB-1:0] vld_q;
	logic [qn_pkg::QB:0] zro_q;
	logic [qn_pkg::OUT_W-1:0] unit [0:L-1];
	logic [qn_pkg::OUT_W-1:0] res_q [0:L-1];
	logic zero_q;
	logic res_valid_q;

	assign adv = !res_valid_q || !res_stall;
	assign req_stall = !adv;

	assign comp[0] = comp_w;
	assign comp[1] = comp_x;
	assign comp[2] = comp_y;
	assign comp[3] = comp_z;

	for (genvar i = 0; i < L; i++) begin : g_front
		assign mag[i] = comp[i][W-1] ? (~comp[i] + W'(1)) : comp[i];
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s1[i] <= mag[i] * mag[i];
				neg_s1[i] <= comp[i][W-1];
				rhs_s2[i] <= XW'(sq_s1[i]) <<< qn_pkg::RHS_SHIFT;
				neg_s2[i] <= neg_s1[i];
			end
		end
		qn_lane #(.XW(XW)) u_lane (
			.clk(clk), .adv(adv), .s(s_s2), .rhs(rhs_s2[i]), .neg(neg_s2[i]),
			.unit(unit[i])
		);
	end

	assign sum = SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]) + SW'(sq_s1[3]);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s2 <= XW'(sum);
			zro_q <= {zro_q[qn_pkg::QB-1:0], (sum == '0)};
			zero_q <= zro_q[qn_pkg::QB];
			if (zro_q[qn_pkg::QB]) begin
				res_q[0] <= qn_pkg::UNIT_ONE_OUT;
				res_q[1] <= '0;
				res_q[2] <= '0;
				res_q[3] <= '0;
			end else begin
				res_q[0] <= unit[0];
				res_q[1] <= unit[1];
				res_q[2] <= unit[2];
				res_q[3] <= unit[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vld_q <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			vld_q <= {vld_q[qn_pkg::QB-2:0], v_s2};
			res_valid_q <= vld_q[qn_pkg::QB-1];
		end
	end

	assign res_valid = res_valid_q;
	assign unit_w = res_q[0];
	assign unit_x = res_q[1];
	assign unit_y = res_q[2];
	assign unit_z = res_q[3];
	assign zero_magnitude = zero_q;

	a_zero_identity: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zero_magnitude |-> unit_w == qn_pkg::UNIT_ONE_OUT
			&& unit_x == '0 && unit_y == '0 && unit_z == '0)
		else $error("zero magnitude result is not identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($signed(unit_x) <= 16384 && $signed(unit_x) >= -16384
			&& $signed(unit_w) <= 16384 && $signed(unit_w) >= -16384))
		else $error("result outside unit range");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !req_stall)
		else $error("request stalled while output register empty");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(unit_y) && $stable(zero_magnitude))
		else $error("stalled result changed");
endmodule

// ===== tb/quaternion_normalise_core_tb.sv =====
// Self-checking testbench for the quaternion normaliser: directed table, random requests, stalls.
module quaternion_normalise_core_tb;
	localparam int CW = qn_pkg::DEF_COMPONENT_WIDTH;
	localparam int N_RANDOM = 1430;
	localparam int LATENCY = 18;

	typedef struct packed {
		logic [qn_pkg::OUT_W-1:0] w;
		logic [qn_pkg::OUT_W-1:0] x;
		logic [qn_pkg::OUT_W-1:0] y;
		logic [qn_pkg::OUT_W-1:0] z;
		logic zm;
	} unit_quat_t;

	typedef struct {
		logic [CW-1:0] c [4];
		bit known;
		unit_quat_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [CW-1:0] comp_w = '0, comp_x = '0, comp_y = '0, comp_z = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [qn_pkg::OUT_W-1:0] unit_w, unit_x, unit_y, unit_z;
	logic zero_magnitude;

	unit_quat_t pending_units [$];
	int mismatches = 0;
	int n_results = 0;
	int n_zero = 0;
	int n_sent = 0;
	bit stim_done = 1'b0;
	bit hold_phase = 1'b0;

	quaternion_normalise_core #(.COMPONENT_WIDTH(CW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.comp_w(comp_w), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
		.res_valid(res_valid), .res_stall(res_stall),
		.unit_w(unit_w), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.zero_magnitude(zero_magnitude)
	);

	always #1 clk = ~clk;

	function automatic logic [qn_pkg::OUT_W-1:0] scale_lane(logic [63:0] mag,
		logic [127:0] sum);
		logic [127:0] rhs, lhs, odd;
		logic [15:0] lo, hi, mid;
		rhs = (128'(mag) * 128'(mag)) << qn_pkg::RHS_SHIFT;
		lo = 0;
		hi = 16'(qn_pkg::UNIT_ONE);
		while (lo < hi) begin
			mid = (lo + hi + 16'd1) >> 1;
			odd = 128'(2 * mid - 1);
			lhs = sum * odd * odd;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 16'd1;
		end
		return lo;
	endfunction

	function automatic unit_quat_t normalise(logic [CW-1:0] c [4]);
		unit_quat_t r;
		logic [63:0] mag [4];
		logic [qn_pkg::OUT_W-1:0] q [4];
		logic [127:0] sum;
		sum = '0;
		for (int i = 0; i < qn_pkg::LANES; i++) begin
			mag[i] = c[i][CW-1] ? 64'((1 << CW) - c[i]) : 64'(c[i]);
			sum += 128'(mag[i]) * 128'(mag[i]);
		end
		if (sum == 0)
			return '{qn_pkg::UNIT_ONE_OUT, '0, '0, '0, 1'b1};
		for (int i = 0; i < qn_pkg::LANES; i++) begin
			q[i] = scale_lane(mag[i], sum);
			if (q[i] > qn_pkg::UNIT_ONE_OUT)
				q[i] = qn_pkg::UNIT_ONE_OUT;
			if (c[i][CW-1])
				q[i] = -q[i];
		end
		r = '{q[0], q[1], q[2], q[3], 1'b0};
		return r;
	endfunction

	task automatic send_request(logic [CW-1:0] c [4], unit_quat_t res);
		req_valid <= 1'b1;
		comp_w <= c[0];
		comp_x <= c[1];
		comp_y <= c[2];
		comp_z <= c[3];
		do @(posedge clk); while (req_stall);
		pending_units.push_back(res);
		n_sent++;
		if ($urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	function automatic logic [CW-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return CW'($urandom_range(0, 15)) - CW'(8);
			3: return '0;
			default: return CW'($urandom);
		endcase
	endfunction

	initial begin
		stim_row_t table_rows [$];
		stim_row_t row;
		logic [CW-1:0] c [4];
		logic [CW-1:0] mn, mx;
		mn = {1'b1, {(CW-1){1'b0}}};
		mx = {1'b0, {(CW-1){1'b1}}};
		row.known = 1'b1;
		row.c = '{'0, '0, '0, '0};
		row.res = '{qn_pkg::UNIT_ONE_OUT, '0, '0, '0, 1'b1};
		table_rows.push_back(row);
		row.c = '{CW'(4096), '0, '0, '0};
		row.res = '{qn_pkg::UNIT_ONE_OUT, '0, '0, '0, 1'b0};
		table_rows.push_back(row);
		row.c = '{'0, mn, '0, '0};
		row.res = '{'0, -qn_pkg::UNIT_ONE_OUT, '0, '0, 1'b0};
		table_rows.push_back(row);
		row.c = '{'0, '0, mx, '0};
		row.res = '{'0, '0, qn_pkg::UNIT_ONE_OUT, '0, 1'b0};
		table_rows.push_back(row);
		row.c = '{'0, '0, '0, CW'(1)};
		row.res = '{'0, '0, '0, qn_pkg::UNIT_ONE_OUT, 1'b0};
		table_rows.push_back(row);
		row.c = '{CW'(-1), '0, '0, '0};
		row.res = '{-qn_pkg::UNIT_ONE_OUT, '0, '0, '0, 1'b0};
		table_rows.push_back(row);
		row.known = 1'b0;
		for (int i = 0; i < 16; i++) begin
			for (int k = 0; k < qn_pkg::LANES; k++)
				row.c[k] = (i >> k) & 1 ? ((i & 8) ? mn : mx) : ((i & 4) ? CW'(1) : mn);
			table_rows.push_back(row);
		end
		row.c = '{mx, mx, mx, mx};
		table_rows.push_back(row);
		row.c = '{mn, mn, mn, mn};
		table_rows.push_back(row);
		row.c = '{CW'(1), CW'(1), CW'(-1), CW'(-1)};
		table_rows.push_back(row);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[i])
			send_request(table_rows[i].c,
				table_rows[i].known ? table_rows[i].res : normalise(table_rows[i].c));
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				hold_phase = 1'b1;
			for (int k = 0; k < qn_pkg::LANES; k++)
				c[k] = rand_comp();
			send_request(c, normalise(c));
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (hold_phase);
		@(posedge clk);
		res_stall <= 1'b1;
		repeat (200) @(posedge clk);
		res_stall <= 1'b0;
		while (!stim_done) begin
			@(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 50) : $urandom_range(1, 3))
					@(posedge clk);
				res_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		unit_quat_t got, exp_u;
		if (arst_n && res_valid && !res_stall) begin
			got = '{unit_w, unit_x, unit_y, unit_z, zero_magnitude};
			n_results++;
			if (zero_magnitude)
				n_zero++;
			if (pending_units.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result w=%0d x=%0d y=%0d z=%0d zm=%0b",
						$signed(unit_w), $signed(unit_x), $signed(unit_y),
						$signed(unit_z), zero_magnitude);
			end else begin
				exp_u = pending_units.pop_front();
				if (got !== exp_u) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp w=%0d x=%0d y=%0d z=%0d zm=%0b",
							$signed(exp_u.w), $signed(exp_u.x), $signed(exp_u.y),
							$signed(exp_u.z), exp_u.zm,
							" got w=%0d x=%0d y=%0d z=%0d zm=%0b",
							$signed(unit_w), $signed(unit_x),
							$signed(unit_y), $signed(unit_z), zero_magnitude);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_units.size() == 0);
		repeat (LATENCY * 2) @(posedge clk);
		$display("Sent %0d requests, checked %0d results (%0d zero magnitude).",
			n_sent, n_results, n_zero);
		$display("Covered extremes, sign patterns, zero input and a long output hold.");
		if (mismatches == 0 && pending_units.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end
endmodule
